### sv/pfbc_pkg.sv
// pfbc_pkg: shared types and constants for the polygon frustum / back-face cull core
// holds the input and result beat structs, the product-stage struct and register codes
// no dependencies

package pfbc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_NEAR_PLANE = 2'd0;
    localparam logic [1:0] CFG_FAR_PLANE  = 2'd1;
    localparam logic [1:0] CFG_SLAB_SLOPE = 2'd2;

    localparam logic signed [31:0] NEAR_PLANE_RESET = 32'sh0001_0000;
    localparam logic signed [31:0] FAR_PLANE_RESET  = 32'sh7FFF_FFFF;
    localparam logic [15:0]        SLAB_SLOPE_RESET = 16'd1;

    localparam logic [23:0] CULL_COUNT_MAX = 24'hFF_FFFF;
    localparam logic [2:0]  VCOUNT_MAX     = 3'd7;

    typedef enum logic [2:0] {
        REASON_NONE = 3'd0,
        REASON_NEAR = 3'd1,
        REASON_FAR  = 3'd2,
        REASON_BACK = 3'd3,
        REASON_X    = 3'd4,
        REASON_Y    = 3'd5
    } cull_reason_t;

    typedef struct packed {
        logic               new_frame;
        logic               is_normal;
        logic               two_sided;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               last_vertex;
    } in_item_t;

    typedef struct packed {
        logic        culled;
        logic [2:0]  cull_reason;
        logic [23:0] culled_total;
    } out_item_t;

    // one item after the multiplies: per-vertex test bits and the dot-product terms
    typedef struct packed {
        logic               new_frame;
        logic               is_normal;
        logic               two_sided;
        logic               last_vertex;
        logic               near_hit;
        logic               far_hit;
        logic               x_inside;
        logic               y_inside;
        logic signed [64:0] prod_x;
        logic signed [64:0] prod_y;
        logic signed [64:0] prod_z;
    } geo_t;

endpackage

### sv/pfbc_vertex_stage.sv
// pfbc_vertex_stage: input register, normal point store, per-vertex multiplies and tests
// feeds a registered product beat to pfbc_poly_stage
// depends on pfbc_pkg

module pfbc_vertex_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pfbc_pkg::in_item_t  s_item,
    input  logic signed [31:0]  near_plane,
    input  logic signed [31:0]  far_plane,
    input  logic [15:0]         slab_slope,
    output logic                geo_valid,
    input  logic                geo_ready,
    output pfbc_pkg::geo_t      geo
);

    typedef struct packed {
        logic               new_frame;
        logic               is_normal;
        logic               two_sided;
        logic               last_vertex;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
    } vtx_t;

    logic               in_valid_reg, in_valid_next;
    vtx_t               vtx_reg, vtx_next;
    logic signed [31:0] normal_x_reg, normal_x_next;
    logic signed [31:0] normal_y_reg, normal_y_next;
    logic signed [31:0] normal_z_reg, normal_z_next;
    logic               geo_valid_reg, geo_valid_next;
    pfbc_pkg::geo_t     geo_reg, geo_next;

    logic               prod_ready;
    logic               s_fire;
    logic signed [16:0] fov_s;
    logic signed [48:0] lim;
    logic signed [48:0] neg_lim;
    logic signed [48:0] x_ext;
    logic signed [48:0] y_ext;

    assign prod_ready = !geo_valid_reg || geo_ready;
    assign s_ready    = !in_valid_reg || prod_ready;
    assign s_fire     = s_valid && s_ready;

    // input side: capture the beat and the vector from it to the held normal point
    always_comb begin
        in_valid_next = in_valid_reg;
        vtx_next      = vtx_reg;
        normal_x_next = normal_x_reg;
        normal_y_next = normal_y_reg;
        normal_z_next = normal_z_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (s_fire) begin
            vtx_next.new_frame   = s_item.new_frame;
            vtx_next.is_normal   = s_item.is_normal;
            vtx_next.two_sided   = s_item.two_sided;
            vtx_next.last_vertex = s_item.last_vertex;
            vtx_next.x           = s_item.coord_x;
            vtx_next.y           = s_item.coord_y;
            vtx_next.z           = s_item.coord_z;
            vtx_next.dx          = 33'(normal_x_reg) - 33'(s_item.coord_x);
            vtx_next.dy          = 33'(normal_y_reg) - 33'(s_item.coord_y);
            vtx_next.dz          = 33'(normal_z_reg) - 33'(s_item.coord_z);
            if (s_item.is_normal) begin
                normal_x_next = s_item.coord_x;
                normal_y_next = s_item.coord_y;
                normal_z_next = s_item.coord_z;
            end
        end
    end

    // slab half-width z*fov at full precision
    assign fov_s   = signed'({1'b0, slab_slope});
    assign lim     = 49'(vtx_reg.z) * 49'(fov_s);
    assign neg_lim = -lim;
    assign x_ext   = 49'(vtx_reg.x);
    assign y_ext   = 49'(vtx_reg.y);

    always_comb begin
        geo_valid_next = geo_valid_reg;
        geo_next       = geo_reg;
        if (prod_ready) begin
            geo_valid_next = in_valid_reg;
            if (in_valid_reg) begin
                geo_next.new_frame   = vtx_reg.new_frame;
                geo_next.is_normal   = vtx_reg.is_normal;
                geo_next.two_sided   = vtx_reg.two_sided;
                geo_next.last_vertex = vtx_reg.last_vertex;
                geo_next.near_hit    = vtx_reg.z > near_plane;
                geo_next.far_hit     = vtx_reg.z < far_plane;
                geo_next.x_inside    = (x_ext > neg_lim) && (x_ext < lim);
                geo_next.y_inside    = (y_ext > neg_lim) && (y_ext < lim);
                geo_next.prod_x      = 65'(vtx_reg.dx) * 65'(vtx_reg.x);
                geo_next.prod_y      = 65'(vtx_reg.dy) * 65'(vtx_reg.y);
                geo_next.prod_z      = 65'(vtx_reg.dz) * 65'(vtx_reg.z);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            geo_valid_reg <= 1'b0;
            normal_x_reg  <= '0;
            normal_y_reg  <= '0;
            normal_z_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            geo_valid_reg <= geo_valid_next;
            normal_x_reg  <= normal_x_next;
            normal_y_reg  <= normal_y_next;
            normal_z_reg  <= normal_z_next;
        end
        vtx_reg <= vtx_next;
        geo_reg <= geo_next;
    end

    assign geo_valid = geo_valid_reg;
    assign geo       = geo_reg;

endmodule

### sv/pfbc_poly_stage.sv
// pfbc_poly_stage: dot-product sign, per-polygon flags, verdict and culled count
// takes product beats from pfbc_vertex_stage, drives the result register
// depends on pfbc_pkg

module pfbc_poly_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                geo_valid,
    output logic                geo_ready,
    input  pfbc_pkg::geo_t      geo,
    output logic                m_valid,
    input  logic                m_ready,
    output pfbc_pkg::out_item_t m_item
);

    logic                m_valid_reg, m_valid_next;
    pfbc_pkg::out_item_t m_item_reg, m_item_next;
    logic [2:0]          vcount_reg, vcount_next;
    logic                near_seen_reg, near_seen_next;
    logic                far_seen_reg, far_seen_next;
    logic                x_seen_reg, x_seen_next;
    logic                y_seen_reg, y_seen_next;
    logic                back_reg, back_next;
    logic [23:0]         count_reg, count_next;

    logic                fire;
    logic signed [66:0]  dot_sum;
    logic                dot_pos;
    logic [23:0]         count_base;
    logic                near_all, far_all, x_all, y_all, back_all;
    pfbc_pkg::cull_reason_t reason;

    assign geo_ready = !m_valid_reg || m_ready;
    assign fire      = geo_valid && geo_ready;

    assign dot_sum = 67'(geo.prod_x) + 67'(geo.prod_y) + 67'(geo.prod_z);
    assign dot_pos = !dot_sum[66] && (dot_sum != '0);

    assign count_base = geo.new_frame ? '0 : count_reg;
    assign near_all   = near_seen_reg || geo.near_hit;
    assign far_all    = far_seen_reg || geo.far_hit;
    assign x_all      = x_seen_reg || geo.x_inside;
    assign y_all      = y_seen_reg || geo.y_inside;
    // facing is fixed on the first vertex of the polygon
    assign back_all   = (vcount_reg == '0) ? (!geo.two_sided && dot_pos) : back_reg;

    always_comb begin
        if (!near_all) begin
            reason = pfbc_pkg::REASON_NEAR;
        end else if (!far_all) begin
            reason = pfbc_pkg::REASON_FAR;
        end else if (back_all) begin
            reason = pfbc_pkg::REASON_BACK;
        end else if (!x_all) begin
            reason = pfbc_pkg::REASON_X;
        end else if (!y_all) begin
            reason = pfbc_pkg::REASON_Y;
        end else begin
            reason = pfbc_pkg::REASON_NONE;
        end
    end

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_item_next    = m_item_reg;
        vcount_next    = vcount_reg;
        near_seen_next = near_seen_reg;
        far_seen_next  = far_seen_reg;
        x_seen_next    = x_seen_reg;
        y_seen_next    = y_seen_reg;
        back_next      = back_reg;
        count_next     = count_reg;
        if (geo_ready) begin
            m_valid_next = 1'b0;
        end
        if (fire) begin
            count_next = count_base;
            if (!geo.is_normal) begin
                if (geo.last_vertex) begin
                    if (reason != pfbc_pkg::REASON_NONE
                            && count_base != pfbc_pkg::CULL_COUNT_MAX) begin
                        count_next = count_base + 24'd1;
                    end
                    m_valid_next             = 1'b1;
                    m_item_next.culled       = reason != pfbc_pkg::REASON_NONE;
                    m_item_next.cull_reason  = reason;
                    m_item_next.culled_total = count_next;
                    vcount_next    = '0;
                    near_seen_next = 1'b0;
                    far_seen_next  = 1'b0;
                    x_seen_next    = 1'b0;
                    y_seen_next    = 1'b0;
                    back_next      = 1'b0;
                end else begin
                    if (vcount_reg != pfbc_pkg::VCOUNT_MAX) begin
                        vcount_next = vcount_reg + 3'd1;
                    end
                    near_seen_next = near_all;
                    far_seen_next  = far_all;
                    x_seen_next    = x_all;
                    y_seen_next    = y_all;
                    back_next      = back_all;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            vcount_reg    <= '0;
            near_seen_reg <= 1'b0;
            far_seen_reg  <= 1'b0;
            x_seen_reg    <= 1'b0;
            y_seen_reg    <= 1'b0;
            back_reg      <= 1'b0;
            count_reg     <= '0;
        end else begin
            m_valid_reg   <= m_valid_next;
            vcount_reg    <= vcount_next;
            near_seen_reg <= near_seen_next;
            far_seen_reg  <= far_seen_next;
            x_seen_reg    <= x_seen_next;
            y_seen_reg    <= y_seen_next;
            back_reg      <= back_next;
            count_reg     <= count_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTH
    a_culled_matches_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.culled == (m_item.cull_reason != pfbc_pkg::REASON_NONE)))
        else $error("culled flag disagrees with cull reason");

    a_reason_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.cull_reason <= pfbc_pkg::REASON_Y))
        else $error("cull reason out of range");

    a_poly_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !geo.is_normal && geo.last_vertex)
            |=> (vcount_reg == '0 && !near_seen_reg && !back_reg && m_valid))
        else $error("polygon state not cleared after last vertex");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && geo.new_frame) |=> (count_reg <= 24'd1))
        else $error("culled count not restarted on new frame");
`endif

endmodule

### sv/polygon_frustum_backface_cull_core.sv
// polygon_frustum_backface_cull_core: top level of the frustum / back-face cull block
// holds the configuration registers; instantiates pfbc_vertex_stage and pfbc_poly_stage
// depends on pfbc_pkg, pfbc_vertex_stage and pfbc_poly_stage
//
//   channel   ports                            payload
//   input     s_valid / s_ready / s_item       pfbc_pkg::in_item_t, one point per beat
//   result    m_valid / m_ready / m_item       pfbc_pkg::out_item_t, one per last vertex
//   config    cfg_valid / cfg_ready            cfg_index, cfg_data, always ready
//
// one beat per cycle sustained unless the result side stalls; a result leaves the result
// register after its last vertex passes the input register and the product register
// the dot-product and slab multiplies sit between input and product registers
// aresetn is synchronous and restores the register defaults and clears all polygon state
// a stalled result holds the pipeline back one stage at a time; no beat is dropped

module polygon_frustum_backface_cull_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pfbc_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output pfbc_pkg::out_item_t m_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    logic signed [31:0] near_plane_reg, near_plane_next;
    logic signed [31:0] far_plane_reg, far_plane_next;
    logic [15:0]        slab_slope_reg, slab_slope_next;

    logic               geo_valid;
    logic               geo_ready;
    pfbc_pkg::geo_t     geo;

    assign cfg_ready = 1'b1;

    always_comb begin
        near_plane_next = near_plane_reg;
        far_plane_next  = far_plane_reg;
        slab_slope_next = slab_slope_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pfbc_pkg::CFG_NEAR_PLANE: near_plane_next = signed'(cfg_data);
                pfbc_pkg::CFG_FAR_PLANE:  far_plane_next  = signed'(cfg_data);
                pfbc_pkg::CFG_SLAB_SLOPE: slab_slope_next = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_plane_reg <= pfbc_pkg::NEAR_PLANE_RESET;
            far_plane_reg  <= pfbc_pkg::FAR_PLANE_RESET;
            slab_slope_reg <= pfbc_pkg::SLAB_SLOPE_RESET;
        end else begin
            near_plane_reg <= near_plane_next;
            far_plane_reg  <= far_plane_next;
            slab_slope_reg <= slab_slope_next;
        end
    end

    pfbc_vertex_stage u_vertex (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .near_plane (near_plane_reg),
        .far_plane  (far_plane_reg),
        .slab_slope (slab_slope_reg),
        .geo_valid  (geo_valid),
        .geo_ready  (geo_ready),
        .geo        (geo)
    );

    pfbc_poly_stage u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .geo_valid (geo_valid),
        .geo_ready (geo_ready),
        .geo       (geo),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

### bench/cull_scoreboard_pkg.sv
// cull_scoreboard_pkg: verdict predictor and result checker for the cull core bench
// tracks registers and per-polygon state, queues predicted verdicts, compares results
// depends on pfbc_pkg
`timescale 1ns / 100ps

package cull_scoreboard_pkg;

    class cull_scoreboard;
        logic signed [31:0]  near_plane;
        logic signed [31:0]  far_plane;
        logic [15:0]         slab_slope;
        logic signed [31:0]  normal_x;
        logic signed [31:0]  normal_y;
        logic signed [31:0]  normal_z;
        logic [2:0]          vertex_count;
        bit                  near_seen;
        bit                  far_seen;
        bit                  x_inside_seen;
        bit                  y_inside_seen;
        bit                  back_facing;
        logic [23:0]         culled_count;
        pfbc_pkg::out_item_t verdict_q[$];
        int unsigned         mismatches;
        int unsigned         results_checked;

        function new();
            near_plane      = pfbc_pkg::NEAR_PLANE_RESET;
            far_plane       = pfbc_pkg::FAR_PLANE_RESET;
            slab_slope      = pfbc_pkg::SLAB_SLOPE_RESET;
            normal_x        = '0;
            normal_y        = '0;
            normal_z        = '0;
            culled_count    = '0;
            mismatches      = 0;
            results_checked = 0;
            clear_polygon();
        endfunction

        function void clear_polygon();
            vertex_count  = '0;
            near_seen     = 1'b0;
            far_seen      = 1'b0;
            x_inside_seen = 1'b0;
            y_inside_seen = 1'b0;
            back_facing   = 1'b0;
        endfunction

        function void set_register(logic [1:0] index, logic [31:0] data);
            case (index)
                pfbc_pkg::CFG_NEAR_PLANE: near_plane = data;
                pfbc_pkg::CFG_FAR_PLANE:  far_plane  = data;
                pfbc_pkg::CFG_SLAB_SLOPE: slab_slope = data[15:0];
                default: ;
            endcase
        endfunction

        function void note_input(pfbc_pkg::in_item_t it);
            logic signed [69:0]     vx;
            logic signed [69:0]     vy;
            logic signed [69:0]     vz;
            logic signed [69:0]     facing_sum;
            logic signed [69:0]     slab;
            pfbc_pkg::cull_reason_t reason;
            pfbc_pkg::out_item_t    verdict;

            if (it.new_frame)
                culled_count = '0;
            if (it.is_normal) begin
                normal_x = it.coord_x;
                normal_y = it.coord_y;
                normal_z = it.coord_z;
                return;
            end

            vx = 70'(it.coord_x);
            vy = 70'(it.coord_y);
            vz = 70'(it.coord_z);

            // facing is decided on the first vertex only, exact 70-bit sum
            if (vertex_count == 0) begin
                facing_sum = (70'(normal_x) - vx) * vx
                           + (70'(normal_y) - vy) * vy
                           + (70'(normal_z) - vz) * vz;
                back_facing = !it.two_sided && (facing_sum > 0);
            end

            if (vz > 70'(near_plane))
                near_seen = 1'b1;
            if (vz < 70'(far_plane))
                far_seen = 1'b1;
            slab = vz * 70'(signed'({1'b0, slab_slope}));
            if (vx > -slab && vx < slab)
                x_inside_seen = 1'b1;
            if (vy > -slab && vy < slab)
                y_inside_seen = 1'b1;
            if (vertex_count != pfbc_pkg::VCOUNT_MAX)
                vertex_count = vertex_count + 3'd1;

            if (!it.last_vertex)
                return;

            if (!near_seen)
                reason = pfbc_pkg::REASON_NEAR;
            else if (!far_seen)
                reason = pfbc_pkg::REASON_FAR;
            else if (back_facing)
                reason = pfbc_pkg::REASON_BACK;
            else if (!x_inside_seen)
                reason = pfbc_pkg::REASON_X;
            else if (!y_inside_seen)
                reason = pfbc_pkg::REASON_Y;
            else
                reason = pfbc_pkg::REASON_NONE;

            if (reason != pfbc_pkg::REASON_NONE && culled_count != pfbc_pkg::CULL_COUNT_MAX)
                culled_count = culled_count + 24'd1;

            verdict.culled       = (reason != pfbc_pkg::REASON_NONE);
            verdict.cull_reason  = reason;
            verdict.culled_total = culled_count;
            verdict_q.push_back(verdict);
            clear_polygon();
        endfunction

        function void check_result(pfbc_pkg::out_item_t got);
            pfbc_pkg::out_item_t want;
            if (verdict_q.size() == 0) begin
                $error("unexpected result beat: culled %0d, cull_reason %0d, culled_total %0d",
                       got.culled, got.cull_reason, got.culled_total);
                mismatches++;
                return;
            end
            want = verdict_q.pop_front();
            results_checked++;
            if (got.culled !== want.culled) begin
                $error("culled: expected %0d, got %0d", want.culled, got.culled);
                mismatches++;
            end
            if (got.cull_reason !== want.cull_reason) begin
                $error("cull_reason: expected %0d, got %0d", want.cull_reason, got.cull_reason);
                mismatches++;
            end
            if (got.culled_total !== want.culled_total) begin
                $error("culled_total: expected %0d, got %0d",
                       want.culled_total, got.culled_total);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return verdict_q.size();
        endfunction
    endclass

endpackage

### bench/testbench.sv
// testbench: drives polygon streams and register settings into the cull core
// checks every result beat against the scoreboard prediction, with random stalls on both sides
// depends on pfbc_pkg, cull_scoreboard_pkg and polygon_frustum_backface_cull_core
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0]         CFG_UNUSED = 2'd3;
    localparam logic signed [31:0] COORD_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX  = 32'sh7FFF_FFFF;
    localparam int                 FIX_ONE    = 65536;
    localparam int                 LONG_HOLD  = 300;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    pfbc_pkg::in_item_t  s_item    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    pfbc_pkg::out_item_t m_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = pfbc_pkg::CFG_NEAR_PLANE;
    logic [31:0]         cfg_data  = '0;

    cull_scoreboard_pkg::cull_scoreboard sb = new();

    bit          input_burst;
    bit          output_eager;
    bit          hold_request;
    int unsigned items_sent;
    int unsigned settings_used;

    polygon_frustum_backface_cull_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return COORD_MAX;
        if (v < -64'sd2147483648)
            return COORD_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic rare_frame();
        return ($urandom_range(0, 24) == 0);
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic pfbc_pkg::in_item_t point(input logic normal,
                                                 input logic signed [31:0] x, y, z,
                                                 input logic last, two_sided, new_frame);
        pfbc_pkg::in_item_t it;
        it.new_frame   = new_frame;
        it.is_normal   = normal;
        it.two_sided   = two_sided;
        it.coord_x     = x;
        it.coord_y     = y;
        it.coord_z     = z;
        it.last_vertex = last;
        return it;
    endfunction

    // depths cluster on both clip planes so the strict compares get exercised
    function automatic logic signed [31:0] rand_depth();
        longint near_v;
        longint far_v;
        near_v = sb.near_plane;
        far_v  = sb.far_plane;
        case ($urandom_range(0, 5))
            0: return clamp32(near_v + int'($urandom_range(0, 4)) - 2);
            1: return clamp32(far_v + int'($urandom_range(0, 4)) - 2);
            2, 3: return clamp32(near_v + longint'($urandom_range(1, 1 << 22)));
            4: return $urandom();
            default: return pick_extreme();
        endcase
    endfunction

    function automatic logic signed [31:0] rand_lateral(input logic signed [31:0] z);
        longint slab;
        slab = longint'(z) * longint'(sb.slab_slope);
        if ($urandom_range(0, 1))
            slab = -slab;
        case ($urandom_range(0, 5))
            0, 1: return clamp32(slab + int'($urandom_range(0, 4)) - 2);
            2, 3: return clamp32(longint'($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return $urandom();
            default: return pick_extreme();
        endcase
    endfunction

    task automatic send_item(input pfbc_pkg::in_item_t it);
        int unsigned gap;
        gap = input_burst ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_polygon(input int unsigned nverts, input bit with_normal,
                                input bit late_normal);
        logic signed [31:0] x, y, z, nx, ny, nz;
        int unsigned        i;
        z = rand_depth();
        x = rand_lateral(z);
        y = rand_lateral(z);
        // normal placed relative to the first vertex to hit both facings and the zero dot
        case ($urandom_range(0, 3))
            0: begin
                nx = clamp32(2 * longint'(x));
                ny = clamp32(2 * longint'(y));
                nz = clamp32(2 * longint'(z));
            end
            1: begin
                nx = x;
                ny = y;
                nz = z;
            end
            2: begin
                nx = '0;
                ny = '0;
                nz = '0;
            end
            default: begin
                nx = $urandom();
                ny = $urandom();
                nz = $urandom();
            end
        endcase
        if (with_normal)
            send_item(point(1'b1, nx, ny, nz, coin(), coin(), rare_frame()));
        for (i = 0; i < nverts; i++) begin
            if (i != 0) begin
                z = rand_depth();
                x = rand_lateral(z);
                y = rand_lateral(z);
            end
            if (late_normal && i == 1)
                send_item(point(1'b1, $urandom(), $urandom(), $urandom(), coin(), coin(),
                                rare_frame()));
            send_item(point(1'b0, x, y, z, i == nverts - 1, coin(), rare_frame()));
        end
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned r;
        int unsigned nverts;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 39) == 0)
                input_burst = !input_burst;
            r = $urandom_range(0, 99);
            nverts = ($urandom_range(0, 6) != 0) ? $urandom_range(3, 4) : $urandom_range(1, 9);
            if (r < 80) begin
                send_polygon(nverts, $urandom_range(0, 9) < 7, 1'b0);
            end else if (r < 90) begin
                send_polygon((nverts < 2) ? 2 : nverts, coin(), 1'b1);
            end else begin
                send_item(point(1'b1, $urandom(), $urandom(), $urandom(), coin(), coin(),
                                rare_frame()));
            end
        end
        input_burst = 1'b0;
    endtask

    // lowers valid, waits out every verdict and lets trailing normals clear the pipe
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(index, data);
    endtask

    task automatic configure(input logic signed [31:0] near_v, far_v, input logic [15:0] fov_v,
                             input bit poke_unused);
        logic [31:0] fov_data;
        fov_data       = $urandom();
        fov_data[15:0] = fov_v;
        write_register(pfbc_pkg::CFG_NEAR_PLANE, near_v);
        write_register(pfbc_pkg::CFG_FAR_PLANE, far_v);
        write_register(pfbc_pkg::CFG_SLAB_SLOPE, fov_data);
        if (poke_unused)
            write_register(CFG_UNUSED, $urandom());
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // result side: random stalls, eager stretches, and one long hold on request
    initial begin
        int unsigned stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end else begin
                stall = output_eager ? 0 : $urandom_range(0, 16);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_item);
            if ($urandom_range(0, 29) == 0)
                output_eager = !output_eager;
        end
    end

    initial begin
        logic signed [31:0] z;
        logic signed [31:0] near_v;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero vertex against the zero normal from reset: near cull
        send_item(point(1'b0, 0, 0, 0, 1'b1, 1'b0, 1'b1));
        // normal with a stray last bit starts a new frame
        send_item(point(1'b1, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, 1'b1, 1'b1));
        send_item(point(1'b0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1, 1'b0));
        send_item(point(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0, 1'b0));
        // normal beyond the first vertex: back face
        send_item(point(1'b1, 2 * FIX_ONE, 0, 4 * FIX_ONE, 1'b0, 1'b0, 1'b0));
        send_item(point(1'b0, FIX_ONE, 0, 2 * FIX_ONE, 1'b0, 1'b0, 1'b0));
        send_item(point(1'b0, -FIX_ONE, FIX_ONE, 3 * FIX_ONE, 1'b0, 1'b0, 1'b0));
        send_item(point(1'b0, 0, 0, 2 * FIX_ONE, 1'b1, 1'b0, 1'b0));
        // same normal reused, two-sided first vertex skips facing
        send_item(point(1'b0, FIX_ONE, 0, 2 * FIX_ONE, 1'b0, 1'b1, 1'b0));
        send_item(point(1'b0, -FIX_ONE, FIX_ONE, 3 * FIX_ONE, 1'b0, 1'b0, 1'b0));
        send_item(point(1'b0, 0, 0, 2 * FIX_ONE, 1'b1, 1'b0, 1'b0));
        // normal equal to the vertex: dot product exactly zero
        send_item(point(1'b1, 5 * FIX_ONE, -3 * FIX_ONE, 7 * FIX_ONE, 1'b0, 1'b0, 1'b0));
        send_item(point(1'b0, 5 * FIX_ONE, -3 * FIX_ONE, 7 * FIX_ONE, 1'b1, 1'b0, 1'b0));
        // x on or outside the slab edge for every vertex
        send_item(point(1'b1, 0, 0, 0, 1'b0, 1'b0, 1'b0));
        send_item(point(1'b0, 3 * FIX_ONE, 0, 2 * FIX_ONE, 1'b0, 1'b0, 1'b0));
        send_item(point(1'b0, -3 * FIX_ONE, 0, 2 * FIX_ONE, 1'b0, 1'b0, 1'b0));
        send_item(point(1'b0, 2 * FIX_ONE, 0, 2 * FIX_ONE, 1'b1, 1'b0, 1'b0));
        // y outside the slab, x inside
        send_item(point(1'b0, 0, 5 * FIX_ONE, 2 * FIX_ONE, 1'b0, 1'b0, 1'b0));
        send_item(point(1'b0, 0, -4 * FIX_ONE, 2 * FIX_ONE, 1'b1, 1'b0, 1'b0));
        // normal arriving mid-polygon does not change the verdict
        send_item(point(1'b0, 0, 0, 4 * FIX_ONE, 1'b0, 1'b0, 1'b0));
        send_item(point(1'b1, 8 * FIX_ONE, 8 * FIX_ONE, 8 * FIX_ONE, 1'b0, 1'b0, 1'b0));
        send_item(point(1'b0, FIX_ONE, FIX_ONE, 4 * FIX_ONE, 1'b1, 1'b0, 1'b0));

        random_traffic(100);
        drain_results();

        configure(COORD_MIN, COORD_MAX, 16'd0, 1'b1);
        random_traffic(100);
        drain_results();

        configure(COORD_MAX, COORD_MIN, 16'hFFFF, 1'b0);
        random_traffic(40);
        drain_results();

        near_v = $urandom_range(0, 8 * FIX_ONE);
        near_v = near_v - 4 * FIX_ONE;
        configure(near_v, near_v + int'($urandom_range(FIX_ONE, 1 << 26)),
                  16'($urandom_range(1, 8)), 1'b1);
        // back up the result side until the input stalls
        hold_request = 1'b1;
        input_burst  = 1'b1;
        repeat (40) begin
            z = rand_depth();
            send_item(point(1'b0, rand_lateral(z), rand_lateral(z), z, 1'b1, coin(), 1'b0));
        end
        input_burst = 1'b0;
        random_traffic(100);
        drain_results();

        configure(32'sd0, 32'sh4000_0000, 16'hFFFF, 1'b0);
        random_traffic(100);
        drain_results();

        configure(-FIX_ONE, 64 * FIX_ONE, 16'd2, 1'b0);
        random_traffic(100);
        drain_results();

        $display("sent %0d input beats under %0d register settings", items_sent,
                 settings_used + 1);
        $display("checked %0d verdicts covering every cull reason and the frame count",
                 sb.results_checked);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
sv/pfbc_pkg.sv
sv/pfbc_vertex_stage.sv
sv/pfbc_poly_stage.sv
sv/polygon_frustum_backface_cull_core.sv
bench/cull_scoreboard_pkg.sv
bench/testbench.sv
